### rtl/ndef_record_tlv_framer_macros.svh
// assertion macros for the ndef record tlv framer
// no dependencies; included by the top level
`ifndef NDEF_RECORD_TLV_FRAMER_MACROS_SVH
`define NDEF_RECORD_TLV_FRAMER_MACROS_SVH

// antecedent holds -> consequent in the same cycle
`define FRM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent holds -> consequent in the next cycle
`define FRM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ndef_frm_pkg.sv
// shared types and constants for the ndef record tlv framer
// no dependencies
`timescale 1ns / 1ps

package ndef_frm_pkg;

    localparam int unsigned MAX_WORDS = 10;
    localparam int unsigned CNT_W     = $clog2(MAX_WORDS + 1);
    localparam int unsigned IDX_W     = $clog2(MAX_WORDS);

    localparam logic [1:0] FUNC_START   = 2'd0;
    localparam logic [1:0] FUNC_TYPE    = 2'd1;
    localparam logic [1:0] FUNC_PAYLOAD = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TOOLONG = 2'd1;
    localparam logic [1:0] ST_SEQ     = 2'd2;

    localparam logic [7:0] TLV_NDEF    = 8'h03;
    localparam logic [7:0] TLV_TERM    = 8'hFE;
    localparam logic [7:0] TLV_LONG    = 8'hFF;
    localparam logic [7:0] HDR_SHORT   = 8'hD0;
    localparam logic [7:0] HDR_LONG    = 8'hC0;
    localparam logic [7:0] TNF_MASK    = 8'h07;
    localparam logic [15:0] SHORT_LIM  = 16'd256;
    localparam logic [16:0] HLEN_SHORT = 17'd3;
    localparam logic [16:0] HLEN_LONG  = 17'd6;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'b001,
        PH_TYPE    = 3'b010,
        PH_PAYLOAD = 3'b100
    } phase_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [2:0]  record_tnf;
        logic [7:0]  type_length;
        logic [15:0] payload_length;
        logic [7:0]  data_byte;
    } frm_item_t;

    typedef struct packed {
        phase_t      phase;
        logic [7:0]  type_left;
        logic [15:0] payload_left;
    } frm_state_t;

    typedef struct packed {
        logic [MAX_WORDS-1:0][7:0] bytes;
        logic [CNT_W-1:0]          count;
        logic                      fin_last;
        logic [1:0]                status;
    } frm_burst_t;

endpackage

### rtl/ndef_frm_encode.sv
// framing logic: one item plus current state -> word burst and next state
// depends on ndef_frm_pkg
`timescale 1ns / 1ps

module ndef_frm_encode (
    input  ndef_frm_pkg::frm_item_t  item,
    input  ndef_frm_pkg::frm_state_t cur,
    output ndef_frm_pkg::frm_burst_t burst,
    output ndef_frm_pkg::frm_state_t nxt
);

    always_comb
    begin
        logic [ndef_frm_pkg::CNT_W-1:0] k;
        logic        short_rec;
        logic [16:0] rec_len;
        logic [7:0]  tl;
        logic [15:0] pl;
        logic        adv;
        logic        err;
        logic [1:0]  err_code;

        k         = '0;
        burst     = '0;
        nxt       = cur;
        tl        = cur.type_left;
        pl        = cur.payload_left;
        adv       = 1'b0;
        err       = 1'b0;
        err_code  = ndef_frm_pkg::ST_SEQ;
        short_rec = item.payload_length < ndef_frm_pkg::SHORT_LIM;
        rec_len   = (short_rec ? ndef_frm_pkg::HLEN_SHORT : ndef_frm_pkg::HLEN_LONG)
                  + {9'd0, item.type_length} + {1'b0, item.payload_length};

        case (item.func)
            ndef_frm_pkg::FUNC_START:
            begin
                if (cur.phase != ndef_frm_pkg::PH_IDLE)
                begin
                    err = 1'b1;
                end
                else if (rec_len[16])
                begin
                    err      = 1'b1;
                    err_code = ndef_frm_pkg::ST_TOOLONG;
                end
                else
                begin
                    burst.bytes[k[ndef_frm_pkg::IDX_W-1:0]] = ndef_frm_pkg::TLV_NDEF;
                    k = k + 1'b1;
                    if (rec_len[15:0] >= {8'd0, ndef_frm_pkg::TLV_LONG})
                    begin
                        burst.bytes[k[ndef_frm_pkg::IDX_W-1:0]] = ndef_frm_pkg::TLV_LONG;
                        k = k + 1'b1;
                        burst.bytes[k[ndef_frm_pkg::IDX_W-1:0]] = rec_len[15:8];
                        k = k + 1'b1;
                    end
                    burst.bytes[k[ndef_frm_pkg::IDX_W-1:0]] = rec_len[7:0];
                    k = k + 1'b1;
                    burst.bytes[k[ndef_frm_pkg::IDX_W-1:0]] =
                        (short_rec ? ndef_frm_pkg::HDR_SHORT : ndef_frm_pkg::HDR_LONG)
                        | ({5'd0, item.record_tnf} & ndef_frm_pkg::TNF_MASK);
                    k = k + 1'b1;
                    burst.bytes[k[ndef_frm_pkg::IDX_W-1:0]] = item.type_length;
                    k = k + 1'b1;
                    if (!short_rec)
                    begin
                        burst.bytes[k[ndef_frm_pkg::IDX_W-1:0]] = 8'd0;
                        k = k + 1'b1;
                        burst.bytes[k[ndef_frm_pkg::IDX_W-1:0]] = 8'd0;
                        k = k + 1'b1;
                        burst.bytes[k[ndef_frm_pkg::IDX_W-1:0]] = item.payload_length[15:8];
                        k = k + 1'b1;
                    end
                    burst.bytes[k[ndef_frm_pkg::IDX_W-1:0]] = item.payload_length[7:0];
                    k   = k + 1'b1;
                    tl  = item.type_length;
                    pl  = item.payload_length;
                    adv = 1'b1;
                end
            end
            ndef_frm_pkg::FUNC_TYPE:
            begin
                if (cur.phase == ndef_frm_pkg::PH_TYPE && cur.type_left != 8'd0)
                begin
                    burst.bytes[k[ndef_frm_pkg::IDX_W-1:0]] = item.data_byte;
                    k   = k + 1'b1;
                    tl  = cur.type_left - 8'd1;
                    adv = 1'b1;
                end
                else
                begin
                    err = 1'b1;
                end
            end
            ndef_frm_pkg::FUNC_PAYLOAD:
            begin
                if (cur.phase == ndef_frm_pkg::PH_PAYLOAD && cur.payload_left != 16'd0)
                begin
                    burst.bytes[k[ndef_frm_pkg::IDX_W-1:0]] = item.data_byte;
                    k   = k + 1'b1;
                    pl  = cur.payload_left - 16'd1;
                    adv = 1'b1;
                end
                else
                begin
                    err = 1'b1;
                end
            end
            default:
            begin
                err = 1'b1;
            end
        endcase

        if (adv)
        begin
            nxt.type_left    = tl;
            nxt.payload_left = pl;
            if (tl != 8'd0)
            begin
                nxt.phase = ndef_frm_pkg::PH_TYPE;
            end
            else if (pl != 16'd0)
            begin
                nxt.phase = ndef_frm_pkg::PH_PAYLOAD;
            end
            else
            begin
                // record complete: close the message
                nxt.phase = ndef_frm_pkg::PH_IDLE;
                burst.bytes[k[ndef_frm_pkg::IDX_W-1:0]] = ndef_frm_pkg::TLV_TERM;
                k = k + 1'b1;
                burst.fin_last = 1'b1;
            end
        end

        if (err)
        begin
            burst          = '0;
            k              = ndef_frm_pkg::CNT_W'(1);
            burst.fin_last = 1'b1;
            burst.status   = err_code;
        end

        burst.count = k;
    end

endmodule

### rtl/ndef_frm_burst.sv
// result register: holds one word burst and hands it out one word per cycle while res_stall is low
// depends on ndef_frm_pkg
`timescale 1ns / 1ps

module ndef_frm_burst (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     load,
    input  ndef_frm_pkg::frm_burst_t burst,
    output logic                     ready,
    output logic                     res_valid,
    input  logic                     res_stall,
    output logic [7:0]               out_byte,
    output logic                     last,
    output logic [1:0]               status
);

    logic [ndef_frm_pkg::MAX_WORDS-1:0][7:0] bytes_reg;
    logic [ndef_frm_pkg::CNT_W-1:0]          count_reg;
    logic [ndef_frm_pkg::IDX_W-1:0]          idx_reg;
    logic                                    valid_reg;
    logic                                    fin_last_reg;
    logic [1:0]                              status_reg;
    logic                                    final_word;

    assign final_word = (ndef_frm_pkg::CNT_W'(idx_reg) + 1'b1) == count_reg;
    // free now, or the final word leaves this cycle
    assign ready      = !valid_reg || (final_word && !res_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (load && ready)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end
        else if (valid_reg && !res_stall)
        begin
            if (final_word)
            begin
                valid_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && ready)
        begin
            bytes_reg    <= burst.bytes;
            count_reg    <= burst.count;
            fin_last_reg <= burst.fin_last;
            status_reg   <= burst.status;
        end
    end

    assign res_valid = valid_reg;
    assign out_byte  = bytes_reg[idx_reg];
    assign last      = fin_last_reg && final_word;
    assign status    = status_reg;

endmodule

### rtl/ndef_record_tlv_framer.sv
// top level of the ndef record tlv framer: input register, framing state, result register
// depends on ndef_frm_pkg, ndef_frm_encode, ndef_frm_burst, ndef_record_tlv_framer_macros.svh
// an accepted word passes the input register, then the result register, before it is offered
// throughput: one input word per cycle while each makes one result word and res_stall is low;
// a start word makes 5 to 10 result words (1 if rejected) and the final data word 2
// reset: asynchronous, active low; clears the framer to idle with no message open
`timescale 1ns / 1ps

`include "ndef_record_tlv_framer_macros.svh"

module ndef_record_tlv_framer (
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [1:0]  func,
    input  logic [2:0]  record_tnf,
    input  logic [7:0]  type_length,
    input  logic [15:0] payload_length,
    input  logic [7:0]  data_byte,
    // result channel
    output logic        res_valid,
    input  logic        res_stall,
    output logic [7:0]  out_byte,
    output logic        last,
    output logic [1:0]  status
);

    // input register stage
    logic                     in_valid_reg;
    ndef_frm_pkg::frm_item_t  in_item_reg;

    // framing state: phase and remaining type / payload counts
    ndef_frm_pkg::frm_state_t state_reg;
    ndef_frm_pkg::frm_state_t state_next;

    ndef_frm_pkg::frm_burst_t burst;
    logic                     burst_ready;
    logic                     accept;
    logic                     take;

    // the held word moves on whenever the result register can take a burst
    assign take       = in_valid_reg && burst_ready;
    assign item_stall = in_valid_reg && !burst_ready;
    assign accept     = item_valid && !item_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (take)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_item_reg.func           <= func;
            in_item_reg.record_tnf     <= record_tnf;
            in_item_reg.type_length    <= type_length;
            in_item_reg.payload_length <= payload_length;
            in_item_reg.data_byte      <= data_byte;
        end
    end

    // state advances exactly when a word's burst is committed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase        <= ndef_frm_pkg::PH_IDLE;
            state_reg.type_left    <= 8'd0;
            state_reg.payload_left <= 16'd0;
        end
        else if (take)
        begin
            state_reg <= state_next;
        end
    end

    ndef_frm_encode u_encode (
        .item  (in_item_reg),
        .cur   (state_reg),
        .burst (burst),
        .nxt   (state_next)
    );

    ndef_frm_burst u_burst (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (take),
        .burst     (burst),
        .ready     (burst_ready),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .out_byte  (out_byte),
        .last      (last),
        .status    (status)
    );

    // a committed burst is always offered on the next cycle
    `FRM_ASSERT_NEXT(a_take_offers, clk, rst_n, take, res_valid, "burst not offered after commit")
    // error words are single and always flagged last
    `FRM_ASSERT_SAME(a_err_last, clk, rst_n, res_valid && status != ndef_frm_pkg::ST_OK,
        last && out_byte == 8'd0, "error word not last or not zero")
    // an ok last word must be the terminator
    `FRM_ASSERT_SAME(a_last_term, clk, rst_n, res_valid && last && status == ndef_frm_pkg::ST_OK,
        out_byte == ndef_frm_pkg::TLV_TERM, "last word is not the terminator")
    // type phase always has type bytes left
    `FRM_ASSERT_SAME(a_type_left, clk, rst_n, state_reg.phase == ndef_frm_pkg::PH_TYPE,
        state_reg.type_left != 8'd0, "type phase with no type bytes left")

endmodule

### verif/ndef_record_tlv_framer_tb.sv
// self-checking testbench for the ndef record tlv framer: queue-fed driver, clocked monitor
// and an in-bench framing predictor; depends on ndef_frm_pkg and ndef_record_tlv_framer
`timescale 1ns / 1ps

module ndef_record_tlv_framer_tb;

    // func code 3 has no meaning, the block must flag it as out of sequence
    localparam logic [1:0] FUNC_RSVD    = 2'd3;
    localparam int unsigned RANDOM_WORDS = 45;
    localparam int unsigned MAX_WAIT     = 4;
    localparam int unsigned PRINT_CAP    = 40;

    // one expected word of the framed stream
    typedef struct packed {
        logic [7:0] octet;
        logic       fin;
        logic [1:0] code;
    } frame_word_t;

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        item_valid     = 1'b0;
    logic        item_stall;
    logic [1:0]  func           = ndef_frm_pkg::FUNC_START;
    logic [2:0]  record_tnf     = 3'd0;
    logic [7:0]  type_length    = 8'd0;
    logic [15:0] payload_length = 16'd0;
    logic [7:0]  data_byte      = 8'd0;
    logic        res_valid;
    logic        res_stall      = 1'b0;
    logic [7:0]  out_byte;
    logic        last;
    logic [1:0]  status;

    ndef_record_tlv_framer uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .func           (func),
        .record_tnf     (record_tnf),
        .type_length    (type_length),
        .payload_length (payload_length),
        .data_byte      (data_byte),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .out_byte       (out_byte),
        .last           (last),
        .status         (status)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // framing state as the predictor sees it
    ndef_frm_pkg::phase_t ph  = ndef_frm_pkg::PH_IDLE;
    logic [7:0]  type_left    = 8'd0;
    logic [15:0] payload_left = 16'd0;

    ndef_frm_pkg::frm_item_t pending_q[$];   // words still to be driven
    frame_word_t framed_q[$];                // framed stream still to come out of the block

    int fail_count   = 0;
    int words_queued = 0;
    int words_sent   = 0;
    int results_seen = 0;
    int error_words  = 0;
    int long_headers = 0;

    // mismatch report; printing is capped so a broken block cannot flood the log
    task automatic report_mismatch(input string what, input int exp_v, input int got_v);
        if (fail_count < PRINT_CAP)
            $display("mismatch at %0t ns: %s expected %0d got %0d (result word %0d)",
                     $time, what, exp_v, got_v, results_seen);
        fail_count++;
    endtask

    task automatic emit_word(input logic [7:0] octet, input logic fin, input logic [1:0] code);
        frame_word_t fw;
        fw.octet = octet;
        fw.fin   = fin;
        fw.code  = code;
        framed_q.push_back(fw);
        if (code != ndef_frm_pkg::ST_OK)
            error_words++;
    endtask

    // after a header or a data byte: pick the next data phase or close the message
    task automatic next_phase();
        if (type_left != 8'd0)
            ph = ndef_frm_pkg::PH_TYPE;
        else if (payload_left != 16'd0)
            ph = ndef_frm_pkg::PH_PAYLOAD;
        else
        begin
            ph = ndef_frm_pkg::PH_IDLE;
            emit_word(ndef_frm_pkg::TLV_TERM, 1'b1, ndef_frm_pkg::ST_OK);
        end
    endtask

    // expected framed words for one accepted input word
    task automatic predict_frame(input ndef_frm_pkg::frm_item_t w);
        logic        short_rec;
        logic [16:0] rec_len;
        logic [7:0]  hdr;
        short_rec = (w.payload_length < ndef_frm_pkg::SHORT_LIM);
        rec_len   = (short_rec ? ndef_frm_pkg::HLEN_SHORT : ndef_frm_pkg::HLEN_LONG)
                    + {9'd0, w.type_length} + {1'b0, w.payload_length};
        hdr       = (short_rec ? ndef_frm_pkg::HDR_SHORT : ndef_frm_pkg::HDR_LONG)
                    | ({5'd0, w.record_tnf} & ndef_frm_pkg::TNF_MASK);
        if (w.func == ndef_frm_pkg::FUNC_START && ph == ndef_frm_pkg::PH_IDLE)
        begin
            if (rec_len > 17'h0FFFF)
                emit_word(8'h00, 1'b1, ndef_frm_pkg::ST_TOOLONG);
            else
            begin
                emit_word(ndef_frm_pkg::TLV_NDEF, 1'b0, ndef_frm_pkg::ST_OK);
                // three-byte tlv length from 255 up
                if (rec_len >= {9'd0, ndef_frm_pkg::TLV_LONG})
                begin
                    emit_word(ndef_frm_pkg::TLV_LONG, 1'b0, ndef_frm_pkg::ST_OK);
                    emit_word(rec_len[15:8], 1'b0, ndef_frm_pkg::ST_OK);
                    emit_word(rec_len[7:0], 1'b0, ndef_frm_pkg::ST_OK);
                end
                else
                    emit_word(rec_len[7:0], 1'b0, ndef_frm_pkg::ST_OK);
                emit_word(hdr, 1'b0, ndef_frm_pkg::ST_OK);
                emit_word(w.type_length, 1'b0, ndef_frm_pkg::ST_OK);
                if (short_rec)
                    emit_word(w.payload_length[7:0], 1'b0, ndef_frm_pkg::ST_OK);
                else
                begin
                    long_headers++;
                    emit_word(8'h00, 1'b0, ndef_frm_pkg::ST_OK);
                    emit_word(8'h00, 1'b0, ndef_frm_pkg::ST_OK);
                    emit_word(w.payload_length[15:8], 1'b0, ndef_frm_pkg::ST_OK);
                    emit_word(w.payload_length[7:0], 1'b0, ndef_frm_pkg::ST_OK);
                end
                type_left    = w.type_length;
                payload_left = w.payload_length;
                next_phase();
            end
        end
        else if (w.func == ndef_frm_pkg::FUNC_TYPE && ph == ndef_frm_pkg::PH_TYPE
                 && type_left != 8'd0)
        begin
            emit_word(w.data_byte, 1'b0, ndef_frm_pkg::ST_OK);
            type_left = type_left - 8'd1;
            next_phase();
        end
        else if (w.func == ndef_frm_pkg::FUNC_PAYLOAD && ph == ndef_frm_pkg::PH_PAYLOAD
                 && payload_left != 16'd0)
        begin
            emit_word(w.data_byte, 1'b0, ndef_frm_pkg::ST_OK);
            payload_left = payload_left - 16'd1;
            next_phase();
        end
        else
            emit_word(8'h00, 1'b1, ndef_frm_pkg::ST_SEQ);
    endtask

    // wait draw for either side: stretches of random idling and stretches of none follow in random order
    function automatic int pick_wait(inout int run_left, inout bit no_idle);
        if (run_left == 0)
        begin
            run_left = $urandom_range(8, 48);
            no_idle  = ($urandom_range(0, 3) == 0);
        end
        run_left--;
        return no_idle ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    task automatic queue_word(input int f, input int tnf, input int tlen,
                              input int plen, input int data);
        ndef_frm_pkg::frm_item_t w;
        w.func           = 2'(f);
        w.record_tnf     = 3'(tnf);
        w.type_length    = 8'(tlen);
        w.payload_length = 16'(plen);
        w.data_byte      = 8'(data);
        pending_q.push_back(w);
        words_queued++;
    endtask

    // stray word with any func but the given one, all other fields random
    task automatic queue_stray(input logic [1:0] skip);
        int f;
        f = $urandom_range(0, 2);
        if (f >= skip)
            f = f + 1;
        queue_word(f, $urandom_range(0, 7), $urandom_range(0, 255), $urandom_range(0, 65535),
                   $urandom_range(0, 255));
    endtask

    // well-formed message with random content; strays land only while the message is open
    task automatic queue_message(input int tnf, input int tlen, input int plen,
                                 input int noise_pct);
        queue_word(ndef_frm_pkg::FUNC_START, tnf, tlen, plen, $urandom_range(0, 255));
        for (int i = 0; i < tlen; i++)
        begin
            if ($urandom_range(0, 99) < noise_pct)
                queue_stray(ndef_frm_pkg::FUNC_TYPE);
            queue_word(ndef_frm_pkg::FUNC_TYPE, $urandom_range(0, 7), $urandom_range(0, 255),
                       $urandom_range(0, 65535), $urandom_range(0, 255));
        end
        for (int i = 0; i < plen; i++)
        begin
            if ($urandom_range(0, 99) < noise_pct)
                queue_stray(ndef_frm_pkg::FUNC_PAYLOAD);
            queue_word(ndef_frm_pkg::FUNC_PAYLOAD, $urandom_range(0, 7), $urandom_range(0, 255),
                       $urandom_range(0, 65535), $urandom_range(0, 255));
        end
    endtask

    // ---------------------------------------------------------------- driver
    // an input word is taken at a rising edge with valid high and stall low;
    // the predictor runs on exactly the fields the block took
    int gap_left    = 0;
    int drv_run     = 0;
    bit drv_no_idle = 1'b0;
    bit word_taken  = 1'b0;

    always @(posedge clk)
    begin
        if (rst_n && item_valid && !item_stall)
        begin
            predict_frame({func, record_tnf, type_length, payload_length, data_byte});
            words_sent++;
            word_taken = 1'b1;
        end
    end

    // inputs move only at the falling edge; a stalled word is held untouched
    always @(negedge clk)
    begin : drive_words
        ndef_frm_pkg::frm_item_t w;
        if (rst_n && (!item_valid || word_taken))
        begin
            word_taken = 1'b0;
            if (gap_left > 0)
            begin
                gap_left--;
                item_valid <= 1'b0;
            end
            else if (pending_q.size() > 0)
            begin
                w = pending_q.pop_front();
                func           <= w.func;
                record_tnf     <= w.record_tnf;
                type_length    <= w.type_length;
                payload_length <= w.payload_length;
                data_byte      <= w.data_byte;
                item_valid     <= 1'b1;
                // gap to leave once this word has been taken
                gap_left = pick_wait(drv_run, drv_no_idle);
            end
            else
                item_valid <= 1'b0;
        end
    end

    // ---------------------------------------------------------------- monitor
    // every result word taken is checked field by field against the oldest expectation
    int stall_left  = 0;
    int mon_run     = 0;
    bit mon_no_idle = 1'b0;
    bit res_taken   = 1'b0;

    always @(posedge clk)
    begin : check_results
        frame_word_t fw;
        if (rst_n && res_valid && !res_stall)
        begin
            results_seen++;
            res_taken = 1'b1;
            if (framed_q.size() == 0)
                report_mismatch("result word with nothing pending, out_byte", -1, out_byte);
            else
            begin
                fw = framed_q.pop_front();
                if (out_byte !== fw.octet)
                    report_mismatch("out_byte", fw.octet, out_byte);
                if (last !== fw.fin)
                    report_mismatch("last", fw.fin, last);
                if (status !== fw.code)
                    report_mismatch("result code", fw.code, status);
            end
        end
    end

    // stall drawn per result word, so it hits header bursts and data bytes alike
    always @(negedge clk)
    begin
        if (res_taken)
        begin
            res_taken  = 1'b0;
            stall_left = pick_wait(mon_run, mon_no_idle);
        end
        if (stall_left > 0)
        begin
            stall_left--;
            res_stall <= 1'b1;
        end
        else
            res_stall <= 1'b0;
    end

    // ---------------------------------------------------------------- stimulus and end of run
    initial
    begin : stimulus
        int base;
        int pick;

        // empty record: header burst closes straight away with the terminator
        queue_word(ndef_frm_pkg::FUNC_START, 3'd0, 8'd0, 16'd0, 8'h00);
        // one type byte and one payload byte, with every kind of misplaced word in between
        queue_word(ndef_frm_pkg::FUNC_START, 3'd7, 8'd1, 16'd1, 8'h00);
        queue_word(ndef_frm_pkg::FUNC_PAYLOAD, 3'd0, 8'd0, 16'd0, 8'hAA); // payload in type phase
        queue_word(ndef_frm_pkg::FUNC_START, 3'd3, 8'd9, 16'd9, 8'h00);   // start while open
        queue_word(FUNC_RSVD, 3'd7, 8'hFF, 16'hFFFF, 8'hFF);              // undefined func
        queue_word(ndef_frm_pkg::FUNC_TYPE, 3'd0, 8'd0, 16'd0, 8'hFF);
        queue_word(ndef_frm_pkg::FUNC_TYPE, 3'd0, 8'd0, 16'd0, 8'h00);    // type in payload phase
        queue_word(ndef_frm_pkg::FUNC_PAYLOAD, 3'd0, 8'd0, 16'd0, 8'h00);
        // data and undefined words with no message open
        queue_word(ndef_frm_pkg::FUNC_TYPE, 3'd0, 8'd0, 16'd0, 8'h5A);
        queue_word(ndef_frm_pkg::FUNC_PAYLOAD, 3'd0, 8'd0, 16'd0, 8'hA5);
        queue_word(FUNC_RSVD, 3'd0, 8'd0, 16'd0, 8'h00);
        // record one byte over the tlv limit, then every length bit set
        queue_word(ndef_frm_pkg::FUNC_START, 3'd5, 8'd255, 16'd65275, 8'h00);
        queue_word(ndef_frm_pkg::FUNC_START, 3'd7, 8'hFF, 16'hFFFF, 8'hFF);
        // type bytes only, then payload bytes only
        queue_word(ndef_frm_pkg::FUNC_START, 3'd6, 8'd2, 16'd0, 8'h00);
        queue_word(ndef_frm_pkg::FUNC_TYPE, 3'd0, 8'd0, 16'd0, 8'h00);
        queue_word(ndef_frm_pkg::FUNC_TYPE, 3'd0, 8'd0, 16'd0, 8'hFF);
        queue_word(ndef_frm_pkg::FUNC_START, 3'd4, 8'd0, 16'd2, 8'h00);
        queue_word(ndef_frm_pkg::FUNC_PAYLOAD, 3'd0, 8'd0, 16'd0, 8'hFF);
        queue_word(ndef_frm_pkg::FUNC_PAYLOAD, 3'd0, 8'd0, 16'd0, 8'h00);

        // the large record: six-byte record header with a three-byte tlv length
        queue_message($urandom_range(0, 7), 0, 256, 5);

        // random mix, mostly small well-formed messages
        base = words_queued;
        while (words_queued - base < RANDOM_WORDS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
                queue_message($urandom_range(0, 7), $urandom_range(0, 4), $urandom_range(0, 8), 15);
            else if (pick < 80)
                queue_stray(ndef_frm_pkg::FUNC_START);
            else if (pick < 90)
                queue_word(ndef_frm_pkg::FUNC_START, $urandom_range(0, 7), $urandom_range(0, 255),
                           $urandom_range(65530, 65535), $urandom_range(0, 255));
            else
            begin
                // message followed by surplus data words after it has closed
                queue_message($urandom_range(0, 7), $urandom_range(0, 3), $urandom_range(1, 6), 0);
                repeat ($urandom_range(1, 2))
                    queue_word($urandom_range(0, 1) ? ndef_frm_pkg::FUNC_PAYLOAD
                                                    : ndef_frm_pkg::FUNC_TYPE,
                               $urandom_range(0, 7), $urandom_range(0, 255),
                               $urandom_range(0, 65535), $urandom_range(0, 255));
            end
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // all words taken, every expected word seen, then a short drain for strays
        while (words_sent < words_queued)
            @(posedge clk);
        while (framed_q.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        $display("run covered %0d input words and %0d result words", words_sent, results_seen);
        $display("of those %0d error results and %0d records with the long header",
                 error_words, long_headers);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // hard stop well beyond the slowest correct run
    initial
    begin : watchdog
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
